FILE: src/cpmr_pkg.sv
// Shared types and constants for the CAN poll module responder.
package cpmr_pkg;

   localparam int NumSlots   = 9;
   localparam int SlotWidth  = 4;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);
   localparam int MinLength  = 3;

   localparam logic [1:0] MODE_POLL = 2'd0;
   localparam logic [1:0] MODE_SLOT = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;

   localparam logic [2:0] REG_POLL_ID    = 3'd0;
   localparam logic [2:0] REG_REPLY_ID   = 3'd1;
   localparam logic [2:0] REG_MODULE_ADR = 3'd2;
   localparam logic [2:0] REG_TYPE_CODE  = 3'd3;
   localparam logic [2:0] REG_MODULE_TYP = 3'd4;
   localparam logic [2:0] REG_STATUS     = 3'd5;
   localparam logic [2:0] REG_HOLD_MS    = 3'd6;

   localparam logic [7:0] CH_IDENT  = 8'h00;
   localparam logic [7:0] CH_STATUS = 8'h01;
   localparam logic [7:0] CH_TEMP_A = 8'h02;
   localparam logic [7:0] CH_TEMP_B = 8'h03;
   localparam logic [7:0] CH_TEMP_C = 8'h04;
   localparam logic [7:0] CH_OUTPUT = 8'h05;
   localparam logic [7:0] CH_A0     = 8'hA0;
   localparam logic [7:0] CH_A1     = 8'hA1;
   localparam logic [7:0] CH_A2     = 8'hA2;

   localparam logic [7:0] IDENT_BYTE3  = 8'h31;
   localparam logic [7:0] IDENT_BYTE4  = 8'h01;
   localparam logic [7:0] IDENT_BYTE5  = 8'h11;
   localparam logic [7:0] OUTPUT_BYTE  = 8'h04;
   localparam logic [7:0] A0_BYTE1     = 8'h03;
   localparam logic [7:0] A2_BYTE3     = 8'h01;

   localparam logic [3:0] SLOT_FLOW_A   = 4'd0;
   localparam logic [3:0] SLOT_FLOW_B   = 4'd1;
   localparam logic [3:0] SLOT_BUF_MID  = 4'd2;
   localparam logic [3:0] SLOT_BUF_BOT  = 4'd3;
   localparam logic [3:0] SLOT_DHW      = 4'd4;
   localparam logic [3:0] SLOT_CIRC     = 4'd5;
   localparam logic [3:0] SLOT_BUF_TOP  = 4'd6;
   localparam logic [3:0] SLOT_CH4SPARE = 4'd7;
   localparam logic [3:0] SLOT_CH5SPARE = 4'd8;

   typedef enum logic [1:0] {
      CMD_POLL,
      CMD_SLOT,
      CMD_TICK
   } cmd_kind_type;

   typedef enum logic [3:0] {
      SEL_NONE,
      SEL_IDENT,
      SEL_STATUS,
      SEL_TEMP_A,
      SEL_TEMP_B,
      SEL_TEMP_C,
      SEL_OUTPUT,
      SEL_A0,
      SEL_A1,
      SEL_A2
   } reply_sel_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [10:0] can_id;
      logic [3:0]  frame_length;
      logic [7:0]  channel;
      logic [15:0] commanded_word;
      logic [3:0]  slot;
      logic signed [15:0] temperature;
   } req_type;

   typedef struct packed {
      logic [10:0] reply_identifier;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  byte4;
      logic [7:0]  byte5;
      logic [7:0]  byte6;
      logic [7:0]  byte7;
      logic [15:0] accepted_word;
      logic [31:0] reply_total;
   } rsp_type;

   typedef struct packed {
      logic [10:0] poll_id;
      logic [10:0] reply_id;
      logic [7:0]  module_address;
      logic [15:0] type_code;
      logic [7:0]  module_type;
      logic [15:0] status_word;
      logic [15:0] hold_ms;
   } cfg_type;

   typedef struct packed {
      cmd_kind_type  kind;
      reply_sel_type sel;
      logic [7:0]    channel;
      logic [15:0]   data;
      logic [SlotWidth-1:0] slot;
   } cmd_type;

endpackage

FILE: src/cpmr_front.sv
// Front end: classifies incoming items into commands for the queue.
module cpmr_front
   import cpmr_pkg::*;
(
   input  cfg_type cfg,
   input  req_type req_payload,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic          keep;
   reply_sel_type sel;

   always_comb begin
      case (req_payload.channel)
         CH_IDENT:  sel = SEL_IDENT;
         CH_STATUS: sel = SEL_STATUS;
         CH_TEMP_A: sel = SEL_TEMP_A;
         CH_TEMP_B: sel = SEL_TEMP_B;
         CH_TEMP_C: sel = SEL_TEMP_C;
         CH_OUTPUT: sel = SEL_OUTPUT;
         CH_A0:     sel = SEL_A0;
         CH_A1:     sel = SEL_A1;
         CH_A2:     sel = SEL_A2;
         default:   sel = SEL_NONE;
      endcase
   end

   always_comb begin
      keep              = 1'b0;
      push_cmd.kind     = CMD_POLL;
      push_cmd.sel      = sel;
      push_cmd.channel  = req_payload.channel;
      push_cmd.data     = req_payload.commanded_word;
      push_cmd.slot     = req_payload.slot;
      case (req_payload.mode)
         MODE_POLL: begin
            keep = (req_payload.can_id == cfg.poll_id) &&
                   (req_payload.frame_length >= 4'(MinLength));
         end
         MODE_SLOT: begin
            keep          = (req_payload.slot < 4'(NumSlots));
            push_cmd.kind = CMD_SLOT;
            push_cmd.data = req_payload.temperature;
         end
         MODE_TICK: begin
            keep          = 1'b1;
            push_cmd.kind = CMD_TICK;
         end
         default: keep = 1'b0;
      endcase
   end

   // items that do nothing are taken and dropped
   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule

FILE: src/cpmr_queue.sv
// Short command queue between the front end and the back end.
module cpmr_queue
   import cpmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   head_ff, head_in;
   logic [QueuePtrW-1:0]   tail_ff, tail_in;
   logic [QueueCntW-1:0]   count_ff, count_in;
   logic                   push, pop;

   assign push_ready = (count_ff != QueueCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entries_ff[head_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == QueuePtrW'(QueueDepth - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[tail_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/cpmr_back.sv
// Back end: debounce, temperature store, reply build and output register.
module cpmr_back
   import cpmr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    pop_valid,
   output logic    pop_ready,
   input  cmd_type pop_cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [15:0] pending_word_ff, pending_word_in;
   logic [15:0] pending_age_ff, pending_age_in;
   logic [15:0] debounced_ff, debounced_in;
   logic [31:0] reply_count_ff, reply_count_in;
   logic [15:0] slots_ff [NumSlots];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        take, is_poll, has_reply, load_rsp;
   logic [7:0]  b1, b2, b3, b4, b5, b6;

   assign pop_ready   = !rsp_valid_ff || rsp_ready;
   assign take        = pop_valid && pop_ready;
   assign is_poll     = (pop_cmd.kind == CMD_POLL);
   assign has_reply   = is_poll && (pop_cmd.sel != SEL_NONE);
   assign load_rsp    = take && has_reply;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      pending_word_in = pending_word_ff;
      pending_age_in  = pending_age_ff;
      debounced_in    = debounced_ff;
      reply_count_in  = reply_count_ff;
      if (take) begin
         case (pop_cmd.kind)
            CMD_POLL: begin
               if (pop_cmd.data != pending_word_ff) begin
                  pending_word_in = pop_cmd.data;
                  pending_age_in  = '0;
               end else if ((debounced_ff != pop_cmd.data) &&
                            (pending_age_ff >= cfg.hold_ms)) begin
                  debounced_in = pop_cmd.data;
               end
               if (has_reply) begin
                  reply_count_in = reply_count_ff + 32'd1;
               end
            end
            CMD_TICK: begin
               if (pending_age_ff != '1) begin
                  pending_age_in = pending_age_ff + 16'd1;
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      b1 = '0;
      b2 = '0;
      b3 = '0;
      b4 = '0;
      b5 = '0;
      b6 = '0;
      case (pop_cmd.sel)
         SEL_IDENT: begin
            {b2, b1} = cfg.type_code;
            b3 = IDENT_BYTE3;
            b4 = IDENT_BYTE4;
            b5 = IDENT_BYTE5;
            b6 = cfg.module_type;
         end
         SEL_STATUS: {b2, b1} = cfg.status_word;
         SEL_TEMP_A: begin
            {b2, b1} = slots_ff[SLOT_BUF_MID];
            {b4, b3} = slots_ff[SLOT_BUF_BOT];
            {b6, b5} = slots_ff[SLOT_FLOW_B];
         end
         SEL_TEMP_B: begin
            {b2, b1} = slots_ff[SLOT_FLOW_A];
            {b4, b3} = slots_ff[SLOT_DHW];
         end
         SEL_TEMP_C: begin
            {b2, b1} = slots_ff[SLOT_CIRC];
            {b4, b3} = slots_ff[SLOT_BUF_TOP];
            {b6, b5} = slots_ff[SLOT_CH4SPARE];
         end
         SEL_OUTPUT: begin
            {b2, b1} = slots_ff[SLOT_CH5SPARE];
            {b4, b3} = pop_cmd.data;
            b5 = OUTPUT_BYTE;
            b6 = OUTPUT_BYTE;
         end
         SEL_A0: b1 = A0_BYTE1;
         SEL_A2: b3 = A2_BYTE3;
         default: ;
      endcase
   end

   always_comb begin
      rsp_in.reply_identifier = cfg.reply_id;
      rsp_in.byte0            = pop_cmd.channel;
      rsp_in.byte1            = b1;
      rsp_in.byte2            = b2;
      rsp_in.byte3            = b3;
      rsp_in.byte4            = b4;
      rsp_in.byte5            = b5;
      rsp_in.byte6            = b6;
      rsp_in.byte7            = cfg.module_address;
      rsp_in.accepted_word    = debounced_in;
      rsp_in.reply_total      = reply_count_in;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_word_ff <= '0;
         pending_age_ff  <= '0;
         debounced_ff    <= '0;
         reply_count_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < NumSlots; i++) begin
            slots_ff[i] <= '0;
         end
      end else begin
         pending_word_ff <= pending_word_in;
         pending_age_ff  <= pending_age_in;
         debounced_ff    <= debounced_in;
         reply_count_ff  <= reply_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         if (take && (pop_cmd.kind == CMD_SLOT)) begin
            slots_ff[pop_cmd.slot] <= pop_cmd.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: src/can_poll_module_responder_unit.sv
// Top level of the CAN poll module responder: registers and the front/back split.
// Takes one item per cycle while the queue has room: poll frames, temperature slot
// writes and millisecond ticks. A reply passes from its poll frame through the
// command queue's entry register and then the output register. It can wait there
// while up to two further commands fill the queue, and after that the input stalls.
// The back end updates its state as it takes each command, which sets the sustained
// rate of one item per cycle while the output is not stalled. The user must write
// registers through the csr_ port only while idle; the block does not enforce this.
module can_poll_module_responder_unit
   import cpmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_payload,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   cfg_type cfg_ff;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_POLL_ID:    cfg_ff.poll_id        <= csr_write_data[10:0];
            REG_REPLY_ID:   cfg_ff.reply_id       <= csr_write_data[10:0];
            REG_MODULE_ADR: cfg_ff.module_address <= csr_write_data[7:0];
            REG_TYPE_CODE:  cfg_ff.type_code      <= csr_write_data;
            REG_MODULE_TYP: cfg_ff.module_type    <= csr_write_data[7:0];
            REG_STATUS:     cfg_ff.status_word    <= csr_write_data;
            REG_HOLD_MS:    cfg_ff.hold_ms        <= csr_write_data;
            default: ;
         endcase
      end
   end

   cpmr_front u_front (
      .cfg         (cfg_ff),
      .req_payload (req_payload),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   cpmr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   cpmr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the CAN poll module responder against a behavioral predictor.
`timescale 1ns / 100ps

module testbench;
   import cpmr_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int CycleLimit   = 1000000;
   localparam int SettleCycles = 10;
   localparam int TailCycles   = 20;
   localparam int HoldOffAt    = 400;
   localparam int HoldOffLen   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_write_data = '0;

   can_poll_module_responder_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #2 clock = ~clock;

   // predictor state
   cfg_type     cfg_shadow = '0;
   logic [15:0] pend_word = '0;
   logic [15:0] pend_age = '0;
   logic [15:0] debounced = '0;
   logic [15:0] slot_temps [NumSlots];
   logic [31:0] reply_count = '0;

   req_type frame_queue [$];
   rsp_type due_replies [$];
   logic [7:0] reply_channels [9] = '{CH_IDENT, CH_STATUS, CH_TEMP_A, CH_TEMP_B, CH_TEMP_C,
                                      CH_OUTPUT, CH_A0, CH_A1, CH_A2};

   int  frames_taken = 0;
   int  replies_seen = 0;
   int  mismatches = 0;
   int  settings_used = 0;
   int  cycle_count = 0;
   int  gap_left = 0;
   int  burst_left = 0;
   int  hold_left = 0;
   bit  hold_off_done = 1'b0;
   int  pattern_left = 0;
   int  ready_odds = 0;
   rsp_type oldest;

   initial begin
      for (int i = 0; i < NumSlots; i++) slot_temps[i] = '0;
   end

   task automatic model_frame(input req_type f);
      rsp_type r;
      if (f.mode == MODE_SLOT) begin
         if (f.slot < 4'(NumSlots)) slot_temps[f.slot] = f.temperature;
         return;
      end
      if (f.mode == MODE_TICK) begin
         if (pend_age != 16'hFFFF) pend_age++;
         return;
      end
      if (f.mode != MODE_POLL) return;
      if (f.can_id != cfg_shadow.poll_id || f.frame_length < 4'(MinLength)) return;

      if (f.commanded_word != pend_word) begin
         pend_word = f.commanded_word;
         pend_age = '0;
      end else if (debounced != f.commanded_word && pend_age >= cfg_shadow.hold_ms) begin
         debounced = f.commanded_word;
      end

      r = '0;
      r.byte0 = f.channel;
      r.byte7 = cfg_shadow.module_address;
      case (f.channel)
         CH_IDENT: begin
            {r.byte2, r.byte1} = cfg_shadow.type_code;
            r.byte3 = IDENT_BYTE3;
            r.byte4 = IDENT_BYTE4;
            r.byte5 = IDENT_BYTE5;
            r.byte6 = cfg_shadow.module_type;
         end
         CH_STATUS: {r.byte2, r.byte1} = cfg_shadow.status_word;
         CH_TEMP_A: begin
            {r.byte2, r.byte1} = slot_temps[SLOT_BUF_MID];
            {r.byte4, r.byte3} = slot_temps[SLOT_BUF_BOT];
            {r.byte6, r.byte5} = slot_temps[SLOT_FLOW_B];
         end
         CH_TEMP_B: begin
            {r.byte2, r.byte1} = slot_temps[SLOT_FLOW_A];
            {r.byte4, r.byte3} = slot_temps[SLOT_DHW];
         end
         CH_TEMP_C: begin
            {r.byte2, r.byte1} = slot_temps[SLOT_CIRC];
            {r.byte4, r.byte3} = slot_temps[SLOT_BUF_TOP];
            {r.byte6, r.byte5} = slot_temps[SLOT_CH4SPARE];
         end
         CH_OUTPUT: begin
            {r.byte2, r.byte1} = slot_temps[SLOT_CH5SPARE];
            {r.byte4, r.byte3} = f.commanded_word;
            r.byte5 = OUTPUT_BYTE;
            r.byte6 = OUTPUT_BYTE;
         end
         CH_A0: r.byte1 = A0_BYTE1;
         CH_A1: ;
         CH_A2: r.byte3 = A2_BYTE3;
         default: return;
      endcase

      reply_count++;
      r.reply_identifier = cfg_shadow.reply_id;
      r.accepted_word = debounced;
      r.reply_total = reply_count;
      due_replies.push_back(r);
   endtask

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            model_frame(req_payload);
            frames_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (frame_queue.size() != 0) begin
               req_payload <= frame_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  if ($urandom_range(0, 2) == 0) gap_left = 0;
                  else gap_left = $urandom_range(1, 10);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each transfer, stalls on its own pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_seen++;
            if (due_replies.size() == 0) begin
               mismatches++;
               $display("%0t ns: unexpected reply, expected none, actual %h", $time, rsp_payload);
            end else begin
               oldest = due_replies.pop_front();
               check_field("reply_identifier", 32'(oldest.reply_identifier),
                           32'(rsp_payload.reply_identifier));
               check_field("byte0", 32'(oldest.byte0), 32'(rsp_payload.byte0));
               check_field("byte1", 32'(oldest.byte1), 32'(rsp_payload.byte1));
               check_field("byte2", 32'(oldest.byte2), 32'(rsp_payload.byte2));
               check_field("byte3", 32'(oldest.byte3), 32'(rsp_payload.byte3));
               check_field("byte4", 32'(oldest.byte4), 32'(rsp_payload.byte4));
               check_field("byte5", 32'(oldest.byte5), 32'(rsp_payload.byte5));
               check_field("byte6", 32'(oldest.byte6), 32'(rsp_payload.byte6));
               check_field("byte7", 32'(oldest.byte7), 32'(rsp_payload.byte7));
               check_field("accepted_word", 32'(oldest.accepted_word),
                           32'(rsp_payload.accepted_word));
               check_field("reply_total", oldest.reply_total, rsp_payload.reply_total);
            end
         end
         if (!hold_off_done && frames_taken >= HoldOffAt) begin
            hold_left = HoldOffLen;
            hold_off_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(8, 80);
               ready_odds = $urandom_range(0, 3);
            end else begin
               pattern_left--;
            end
            case (ready_odds)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("%0t ns: timeout, %0d replies still due", $time, due_replies.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic req_type make_frame(input logic [1:0] mode, input logic [10:0] can_id,
                                          input logic [3:0] len, input logic [7:0] channel,
                                          input logic [15:0] word, input logic [3:0] slot,
                                          input logic [15:0] temp);
      req_type f;
      f.mode = mode;
      f.can_id = can_id;
      f.frame_length = len;
      f.channel = channel;
      f.commanded_word = word;
      f.slot = slot;
      f.temperature = temp;
      return f;
   endfunction

   function automatic logic [15:0] pick_extreme(input int bits);
      logic [15:0] mask;
      mask = 16'((32'd1 << bits) - 1);
      case ($urandom_range(0, 3))
         0: return '0;
         1: return mask;
         default: return 16'($urandom) & mask;
      endcase
   endfunction

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         REG_POLL_ID:    cfg_shadow.poll_id = value[10:0];
         REG_REPLY_ID:   cfg_shadow.reply_id = value[10:0];
         REG_MODULE_ADR: cfg_shadow.module_address = value[7:0];
         REG_TYPE_CODE:  cfg_shadow.type_code = value;
         REG_MODULE_TYP: cfg_shadow.module_type = value[7:0];
         REG_STATUS:     cfg_shadow.status_word = value;
         REG_HOLD_MS:    cfg_shadow.hold_ms = value;
         default: ;
      endcase
   endtask

   task automatic program_settings(input cfg_type s);
      write_reg(REG_POLL_ID, 16'(s.poll_id));
      write_reg(REG_REPLY_ID, 16'(s.reply_id));
      write_reg(REG_MODULE_ADR, 16'(s.module_address));
      write_reg(REG_TYPE_CODE, s.type_code);
      write_reg(REG_MODULE_TYP, 16'(s.module_type));
      write_reg(REG_STATUS, s.status_word);
      write_reg(REG_HOLD_MS, s.hold_ms);
      @(posedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (frame_queue.size() != 0 || req_valid || due_replies.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic queue_random_frames(input int count);
      req_type f;
      logic [15:0] cur_word;
      int pick;
      cur_word = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         f = make_frame(MODE_TICK, 11'($urandom), 4'($urandom), 8'($urandom),
                        16'($urandom), 4'($urandom), 16'($urandom));
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            f.mode = MODE_POLL;
            if ($urandom_range(0, 4) == 0)
               cur_word = $urandom_range(0, 1) ? 16'($urandom)
                                               : cur_word ^ (16'h1 << $urandom_range(0, 15));
            if ($urandom_range(0, 9) != 0) f.commanded_word = cur_word;
            if ($urandom_range(0, 9) < 8) f.can_id = cfg_shadow.poll_id;
            pick = $urandom_range(0, 9);
            if (pick < 7) f.frame_length = 4'($urandom_range(MinLength, 8));
            else if (pick < 8) f.frame_length = 4'($urandom_range(9, 15));
            else f.frame_length = 4'($urandom_range(0, MinLength - 1));
            if ($urandom_range(0, 9) < 8) f.channel = reply_channels[$urandom_range(0, 8)];
         end else if (pick < 70) begin
            f.mode = MODE_SLOT;
            if ($urandom_range(0, 9) < 8) f.slot = 4'($urandom_range(0, NumSlots - 1));
            case ($urandom_range(0, 9))
               0: f.temperature = 16'h7FFF;
               1: f.temperature = 16'h8000;
               2: f.temperature = 16'hFFFF;
               3: f.temperature = 16'h0000;
               default: ;
            endcase
         end else if (pick >= 96) begin
            f.mode = MODE_UNUSED;
         end
         frame_queue.push_back(f);
      end
   endtask

   initial begin
      cfg_type s;
      logic [15:0] hold_choices [6];
      hold_choices = '{16'd0, 16'd1, 16'd4, 16'd12, 16'd30, 16'hFFFF};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // identification reply under reset settings
      frame_queue.push_back(make_frame(MODE_POLL, 11'd0, 4'd3, CH_IDENT, 16'h0, 4'd0, 16'h0));
      wait_idle();

      s.poll_id = 11'h7FF;
      s.reply_id = 11'h7FF;
      s.module_address = 8'hFF;
      s.type_code = 16'hFFFF;
      s.module_type = 8'h5A;
      s.status_word = 16'h8000;
      s.hold_ms = 16'd0;
      program_settings(s);

      @(negedge clock);
      for (int k = 0; k < NumSlots; k++)
         frame_queue.push_back(make_frame(MODE_SLOT, 11'd0, 4'd0, 8'd0, 16'd0, 4'(k),
                                          k == 0 ? 16'h7FFF : k == 1 ? 16'h8000
                                                            : 16'(16'h1111 * k)));
      // out-of-range slot is dropped
      frame_queue.push_back(make_frame(MODE_SLOT, 11'd0, 4'd0, 8'd0, 16'd0, 4'hF, 16'hFFFF));
      for (int k = 0; k < 9; k++)
         frame_queue.push_back(make_frame(MODE_POLL, 11'h7FF, 4'd8, reply_channels[k],
                                          16'hFFFF, 4'd0, 16'd0));
      // unknown channel, overlong: no reply, still moves the pending word
      frame_queue.push_back(make_frame(MODE_POLL, 11'h7FF, 4'hF, 8'hFF, 16'h0, 4'd0, 16'd0));
      frame_queue.push_back(make_frame(MODE_POLL, 11'h7FF, 4'd2, CH_IDENT, 16'h0, 4'd0, 16'd0));
      frame_queue.push_back(make_frame(MODE_POLL, 11'h000, 4'd8, CH_STATUS, 16'h0, 4'd0, 16'd0));
      frame_queue.push_back(make_frame(MODE_UNUSED, 11'h7FF, 4'd8, CH_IDENT, 16'h0, 4'd0, 16'd0));
      frame_queue.push_back(make_frame(MODE_TICK, 11'h7FF, 4'd8, CH_IDENT, 16'h0, 4'd0, 16'd0));
      frame_queue.push_back(make_frame(MODE_POLL, 11'h7FF, 4'd9, CH_OUTPUT, 16'h0, 4'd0, 16'd0));
      wait_idle();

      for (int phase = 0; phase < 6; phase++) begin
         s.poll_id = 11'(pick_extreme(11));
         s.reply_id = 11'(pick_extreme(11));
         s.module_address = 8'(pick_extreme(8));
         s.type_code = pick_extreme(16);
         s.module_type = 8'(pick_extreme(8));
         s.status_word = pick_extreme(16);
         s.hold_ms = hold_choices[phase];
         program_settings(s);
         @(negedge clock);
         queue_random_frames(200);
         wait_idle();
      end
      repeat (TailCycles) @(posedge clock);

      $display("Ran %0d frames across %0d register settings, %0d replies compared.",
               frames_taken, settings_used, replies_seen);
      $display("Included directed channel checks, debounce hold times and a long output stall.");
      if (mismatches == 0 && due_replies.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
